/* hw/rtl/ps2se_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 scan code sequence encoder package
// Shared payload types, register indexes, status codes and the fixed byte
// sequences for Pause and Print Screen.
// ----------------------------------------------------------------------------
package ps2se_pkg;

  // Longest sequence that one event can produce (set 2 Pause)
  localparam int unsigned MaxSeq = 8;
  localparam int unsigned LenW   = $clog2(MaxSeq + 1);

  typedef logic [7:0] byte_t;
  // Element 0 is the first byte on the wire
  typedef byte_t [MaxSeq-1:0] seq_bytes_t;

  // Input item
  typedef struct packed {
    logic [15:0] key_code;
    logic [1:0]  key_state;
    logic        is_key_event;
    logic        code_known;
    logic [8:0]  set1_scan;
    logic [8:0]  set2_scan;
  } in_t;

  // Result item
  typedef struct packed {
    byte_t      out_byte;
    logic [1:0] status;
    logic       last;
  } out_t;

  // Configuration as seen by the decoder
  typedef struct packed {
    logic [1:0]  code_set;
    logic        translation_on;
    logic [15:0] pause_key_code;
    logic [15:0] sysrq_key_code;
  } cfg_t;

  // Decoded sequence handed from the decoder to the serializer
  typedef struct packed {
    seq_bytes_t      bytes;
    logic [LenW-1:0] len;
    logic [1:0]      status;
  } seq_t;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegScanSet     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTranslation = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPauseCode   = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSysrqCode   = 2'd3;
  localparam int unsigned CfgDataW = 16;

  // Register reset values
  localparam logic [1:0]  RstScanSet     = 2'd2;
  localparam logic        RstTranslation = 1'b1;
  localparam logic [15:0] RstPauseCode   = 16'd119;
  localparam logic [15:0] RstSysrqCode   = 16'd99;

  // Result status
  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StNone  = 2'd1;
  localparam logic [1:0] StUnsup = 2'd2;

  // Key state codes
  localparam logic [1:0] KsReleased = 2'd0;
  localparam logic [1:0] KsPressed  = 2'd1;
  localparam logic [1:0] KsInvalid  = 2'd3;

  // Scan set codes
  localparam logic [1:0] ScanSetOff = 2'd0;
  localparam logic [1:0] ScanSet1   = 2'd1;
  localparam logic [1:0] ScanSet3   = 2'd3;

  // Protocol bytes
  localparam byte_t PfxExt    = 8'he0;
  localparam byte_t PfxBreak  = 8'hf0;
  localparam byte_t Set1Break = 8'h80;

  // Fixed sequences, written highest element first (element 0 goes out first)
  localparam seq_bytes_t S1Pause    = {8'h00, 8'h00, 8'hc5, 8'h9d,
                                       8'he1, 8'h45, 8'h1d, 8'he1};
  localparam seq_bytes_t S2Pause    = {8'h77, 8'hf0, 8'h14, 8'hf0,
                                       8'he1, 8'h77, 8'h14, 8'he1};
  localparam seq_bytes_t S1PrtMake  = {8'h00, 8'h00, 8'h00, 8'h00,
                                       8'h37, 8'he0, 8'h2a, 8'he0};
  localparam seq_bytes_t S1PrtBreak = {8'h00, 8'h00, 8'h00, 8'h00,
                                       8'haa, 8'he0, 8'hb7, 8'he0};
  localparam seq_bytes_t S2PrtMake  = {8'h00, 8'h00, 8'h00, 8'h00,
                                       8'h7c, 8'he0, 8'h12, 8'he0};
  localparam seq_bytes_t S2PrtBreak = {8'h00, 8'h00, 8'h12, 8'hf0,
                                       8'he0, 8'h7c, 8'hf0, 8'he0};

endpackage

/* hw/rtl/ps2_scancode_sequence_encoder.sv */
// ----------------------------------------------------------------------------
// PS/2 scan code sequence encoder
// Converts key events into PS/2 scan code set 1 or set 2 byte sequences.
// ----------------------------------------------------------------------------
// Each accepted key event produces one to eight result transfers, one byte
// per transfer, with last set on the final one. Events land in an input
// register, are decoded combinationally into a complete sequence, and that
// sequence is loaded into a shift register that drives the output port
// directly from flops. A sequence has 1 to 8 bytes (8 for set 2 Pause), and
// the serializer puts out one byte per cycle while the output is not stalled.
// The next event is decoded and loaded in the same cycle the last byte of the
// previous one transfers, so with no stall the output runs without gaps, and
// one more event may wait in the input register meanwhile. The first result
// is valid once its event has passed the input register and been loaded into
// the shift register.
// Rejected events (not a key event, key code zero, invalid key state, scan
// set 0 or 3, or an unknown ordinary key) give one result with status
// unsupported; a released or repeated Pause gives one result with status
// "no output". Configuration writes take effect on the next clock and are
// expected only while the block is idle.
// ----------------------------------------------------------------------------
module ps2_scancode_sequence_encoder import ps2se_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // event input
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_t                 in_data_i,
  // byte output
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_t                out_data_o
);

  cfg_t cfg_q;
  in_t  evt_q;
  logic evt_vld_q;
  seq_t seq;
  logic ser_ready;
  logic load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.code_set       <= RstScanSet;
      cfg_q.translation_on <= RstTranslation;
      cfg_q.pause_key_code <= RstPauseCode;
      cfg_q.sysrq_key_code <= RstSysrqCode;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegScanSet:     cfg_q.code_set       <= cfg_wdata_i[1:0];
        RegTranslation: cfg_q.translation_on <= cfg_wdata_i[0];
        RegPauseCode:   cfg_q.pause_key_code <= cfg_wdata_i;
        RegSysrqCode:   cfg_q.sysrq_key_code <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register: holds an event until the serializer can take it
  assign load       = evt_vld_q && ser_ready;
  assign in_stall_o = evt_vld_q && !ser_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evt_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      evt_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      evt_q <= in_data_i;
    end
  end

  ps2se_decode u_decode (
    .evt_i (evt_q),
    .cfg_i (cfg_q),
    .seq_o (seq)
  );

  ps2se_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .seq_i       (seq),
    .ready_o     (ser_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* hw/rtl/ps2se_decode.sv */
// ----------------------------------------------------------------------------
// PS/2 event decoder
// Turns one registered key event into its full byte sequence (or a status).
// ----------------------------------------------------------------------------
module ps2se_decode import ps2se_pkg::*; (
  input  in_t  evt_i,
  input  cfg_t cfg_i,
  output seq_t seq_o
);

  logic       reject;
  logic       set1;
  logic [8:0] enc;
  byte_t      scan;
  logic [2:0] n;

  assign reject = !evt_i.is_key_event || (evt_i.key_code == 16'd0) ||
                  (evt_i.key_state == KsInvalid) ||
                  (cfg_i.code_set == ScanSetOff) || (cfg_i.code_set == ScanSet3);
  assign set1   = cfg_i.translation_on || (cfg_i.code_set == ScanSet1);
  assign enc    = set1 ? evt_i.set1_scan : evt_i.set2_scan;

  always_comb begin
    seq_o        = '0;
    seq_o.len    = LenW'(1);
    seq_o.status = StOk;
    scan         = enc[7:0];
    n            = 3'd0;
    if (reject) begin
      seq_o.status = StUnsup;
    end else if (evt_i.key_code == cfg_i.pause_key_code) begin
      // Pause has no break code; only a press produces bytes
      if (evt_i.key_state != KsPressed) begin
        seq_o.status = StNone;
      end else if (set1) begin
        seq_o.bytes = S1Pause;
        seq_o.len   = LenW'(6);
      end else begin
        seq_o.bytes = S2Pause;
        seq_o.len   = LenW'(8);
      end
    end else if (evt_i.key_code == cfg_i.sysrq_key_code) begin
      if (evt_i.key_state == KsReleased) begin
        seq_o.bytes = set1 ? S1PrtBreak : S2PrtBreak;
        seq_o.len   = set1 ? LenW'(4) : LenW'(6);
      end else begin
        seq_o.bytes = set1 ? S1PrtMake : S2PrtMake;
        seq_o.len   = LenW'(4);
      end
    end else if (!evt_i.code_known) begin
      seq_o.status = StUnsup;
    end else begin
      if (enc[8]) begin
        seq_o.bytes[n] = PfxExt;
        n              = n + 3'd1;
      end
      if (evt_i.key_state == KsReleased) begin
        if (set1) begin
          scan = scan | Set1Break;
        end else begin
          seq_o.bytes[n] = PfxBreak;
          n              = n + 3'd1;
        end
      end
      seq_o.bytes[n] = scan;
      seq_o.len      = LenW'(n) + LenW'(1);
    end
  end

endmodule

/* hw/rtl/ps2se_serial.sv */
// ----------------------------------------------------------------------------
// PS/2 sequence serializer
// Holds one decoded sequence and shifts it out one result per transfer.
// ----------------------------------------------------------------------------
module ps2se_serial import ps2se_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  seq_t seq_i,
  output logic ready_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  seq_bytes_t      bytes_q, bytes_d;
  logic [LenW-1:0] cnt_q, cnt_d;
  logic [1:0]      status_q, status_d;
  logic            xfer;

  assign xfer    = out_valid_o && !out_stall_i;
  // Free when empty or when the final byte leaves this cycle
  assign ready_o = (cnt_q == '0) || ((cnt_q == LenW'(1)) && !out_stall_i);

  always_comb begin
    bytes_d  = bytes_q;
    cnt_d    = cnt_q;
    status_d = status_q;
    if (load_i) begin
      bytes_d  = seq_i.bytes;
      cnt_d    = seq_i.len;
      status_d = seq_i.status;
    end else if (xfer) begin
      for (int i = 0; i < MaxSeq - 1; i++) begin
        bytes_d[i] = bytes_q[i+1];
      end
      bytes_d[MaxSeq-1] = '0;
      cnt_d             = cnt_q - LenW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q  <= bytes_d;
    status_q <= status_d;
  end

  assign out_valid_o         = (cnt_q != '0);
  assign out_data_o.out_byte = bytes_q[0];
  assign out_data_o.status   = status_q;
  assign out_data_o.last     = (cnt_q == LenW'(1));

endmodule
